>>> src/bis_pkg.sv
package bis_pkg;

  // source store geometry
  localparam int unsigned SRC_MAX_W  = 256;
  localparam int unsigned SRC_MAX_H  = 256;
  localparam int unsigned DST_MAX    = 4096;
  localparam int unsigned FRAC_BITS  = 8;

  localparam int unsigned POS_W      = 12;
  localparam int unsigned SDIM_W     = 9;
  localparam int unsigned DDIM_W     = 13;
  localparam int unsigned COORD_W    = $clog2(SRC_MAX_W);
  localparam int unsigned ROW_W      = $clog2(SRC_MAX_H);
  localparam int unsigned PROD_W     = POS_W + SDIM_W;
  localparam int unsigned QUO_W      = COORD_W + FRAC_BITS;
  localparam int unsigned WGT_W      = 2 * FRAC_BITS + 1;
  localparam int unsigned BANK_DEPTH = (SRC_MAX_W * SRC_MAX_H) / 4;
  localparam int unsigned BANK_AW    = $clog2(BANK_DEPTH);
  localparam int unsigned PIX_W      = 32;

  // register map
  typedef enum logic [1:0] {
    REG_SRC_W = 2'b00,
    REG_SRC_H = 2'b01,
    REG_DST_W = 2'b10,
    REG_DST_H = 2'b11
  } cfg_reg_t;

  // command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  // transaction traveling down the pipeline
  typedef struct packed {
    logic               vld;
    logic               cmd;
    logic               ok;
    logic [POS_W-1:0]   px;
    logic [POS_W-1:0]   py;
    logic [PIX_W-1:0]   rgba;
  } pkt_t;

endpackage

>>> src/bis_ram.sv
module bis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/bis_div.sv
module bis_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [bis_pkg::PROD_W-1:0]  prod,
  input  logic [bis_pkg::DDIM_W-1:0]  den,
  output logic [bis_pkg::QUO_W-1:0]   quo
);

  localparam int unsigned QW = bis_pkg::QUO_W;
  localparam int unsigned RW = bis_pkg::DDIM_W;
  localparam int unsigned FB = bis_pkg::FRAC_BITS;
  localparam int unsigned PW = bis_pkg::PROD_W;

  logic [RW-1:0] rem_r [QW];
  logic [QW-1:0] lo_r  [QW];
  logic [QW-1:0] q_r   [QW];

  // numerator is prod << FB; quotient fits QW bits, so the top bits seed the remainder
  logic [RW-1:0] rem_init;
  logic [QW-1:0] lo_init;
  logic [PW+FB-1:0] num;

  assign num      = {prod, {FB{1'b0}}};
  assign rem_init = RW'(num >> QW);
  assign lo_init  = num[QW-1:0];

  // one restoring step per stage
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [QW-1:0] lo_in;
    logic [QW-1:0] q_in;
    logic [RW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = rem_init;
      assign lo_in  = lo_init;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign lo_in  = lo_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign trial = {rem_in, lo_in[QW-1]};
    assign ge    = (trial >= {1'b0, den});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? RW'(trial - {1'b0, den}) : trial[RW-1:0];
        lo_r[k]  <= {lo_in[QW-2:0], 1'b0};
        q_r[k]   <= {q_in[QW-2:0], ge};
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule

>>> src/bis_interp.sv
module bis_interp (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic [3:0][bis_pkg::PIX_W-1:0]          pix,
  input  logic [3:0][bis_pkg::WGT_W-1:0]          wgt,
  output logic [bis_pkg::PIX_W-1:0]               rgba
);

  localparam int unsigned MW = bis_pkg::WGT_W + 8;
  localparam int unsigned SW = MW + 2;

  logic [MW-1:0] prod_r [4][4];

  // weight times channel, registered
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        for (int k = 0; k < 4; k++) begin
          prod_r[c][k] <= MW'(wgt[k]) * MW'(pix[k][8*c +: 8]);
        end
      end
    end
  end

  // sum the four taps, truncate the fraction, saturate
  always_comb begin
    logic [SW-1:0] sum;
    logic [SW-1:0] sh;
    for (int c = 0; c < 4; c++) begin
      sum = SW'(prod_r[c][0]) + SW'(prod_r[c][1]) + SW'(prod_r[c][2]) + SW'(prod_r[c][3]);
      sh  = sum >> (2 * bis_pkg::FRAC_BITS);
      rgba[8*c +: 8] = (sh > SW'(255)) ? 8'hff : sh[7:0];
    end
  end

endmodule

>>> src/bilinear_image_scaler_unit.sv
// Bilinear RGBA scaler. Load transactions (cmd 0) write one source pixel into a
// 256x256 store split into four banks by column and row parity, so the four
// neighbours of a destination pixel are read in parallel. Compute transactions
// (cmd 1) return one interpolated pixel; out-of-range transactions give no result.
// The pipeline accepts one transaction per clock unless the output stalls;
// the 16-stage coordinate divider (one quotient bit per stage) is most of its
// depth. Configuration may only be written while idle.
module bilinear_image_scaler_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [11:0] in_pos_x,
  input  logic [11:0] in_pos_y,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_x,
  output logic [11:0] out_y,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned SDW = bis_pkg::SDIM_W;
  localparam int unsigned DDW = bis_pkg::DDIM_W;
  localparam int unsigned CW  = bis_pkg::COORD_W;
  localparam int unsigned RW  = bis_pkg::ROW_W;
  localparam int unsigned FB  = bis_pkg::FRAC_BITS;
  localparam int unsigned QW  = bis_pkg::QUO_W;
  localparam int unsigned WW  = bis_pkg::WGT_W;
  localparam int unsigned AW  = bis_pkg::BANK_AW;
  localparam int unsigned PW  = bis_pkg::PROD_W;

  // configuration registers
  logic [SDW-1:0] src_w_r, src_h_r;
  logic [DDW-1:0] dst_w_r, dst_h_r;
  logic           cfg_wr;
  bis_pkg::cfg_reg_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = bis_pkg::cfg_reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= SDW'(bis_pkg::SRC_MAX_W);
      src_h_r <= SDW'(bis_pkg::SRC_MAX_H);
      dst_w_r <= DDW'(256);
      dst_h_r <= DDW'(256);
    end else if (cfg_wr) begin
      case (cfg_idx)
        bis_pkg::REG_SRC_W: src_w_r <= cfg_pwdata[SDW-1:0];
        bis_pkg::REG_SRC_H: src_h_r <= cfg_pwdata[SDW-1:0];
        bis_pkg::REG_DST_W: dst_w_r <= cfg_pwdata[DDW-1:0];
        bis_pkg::REG_DST_H: dst_h_r <= cfg_pwdata[DDW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      bis_pkg::REG_SRC_W: cfg_prdata = 32'(src_w_r);
      bis_pkg::REG_SRC_H: cfg_prdata = 32'(src_h_r);
      bis_pkg::REG_DST_W: cfg_prdata = 32'(dst_w_r);
      bis_pkg::REG_DST_H: cfg_prdata = 32'(dst_h_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // effective sizes: zero reads as one, large values saturate
  logic [SDW-1:0] sw, sh;
  logic [DDW-1:0] dw, dh;

  assign sw = (src_w_r == '0) ? SDW'(1) :
              (src_w_r > SDW'(bis_pkg::SRC_MAX_W)) ? SDW'(bis_pkg::SRC_MAX_W) : src_w_r;
  assign sh = (src_h_r == '0) ? SDW'(1) :
              (src_h_r > SDW'(bis_pkg::SRC_MAX_H)) ? SDW'(bis_pkg::SRC_MAX_H) : src_h_r;
  assign dw = (dst_w_r == '0) ? DDW'(1) :
              (dst_w_r > DDW'(bis_pkg::DST_MAX)) ? DDW'(bis_pkg::DST_MAX) : dst_w_r;
  assign dh = (dst_h_r == '0) ? DDW'(1) :
              (dst_h_r > DDW'(bis_pkg::DST_MAX)) ? DDW'(bis_pkg::DST_MAX) : dst_h_r;

  // whole pipeline advances together when the output register can move
  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // stage a: capture transaction, range check, coordinate products
  bis_pkg::pkt_t a_pkt_r;
  bis_pkg::pkt_t a_pkt_nxt;
  logic [PW-1:0] a_px_r, a_py_r;

  always_comb begin
    a_pkt_nxt.vld  = in_valid;
    a_pkt_nxt.cmd  = in_cmd;
    a_pkt_nxt.px   = in_pos_x;
    a_pkt_nxt.py   = in_pos_y;
    a_pkt_nxt.rgba = {in_alpha, in_blue, in_green, in_red};
    if (in_cmd == bis_pkg::CMD_COMPUTE) begin
      a_pkt_nxt.ok = (13'(in_pos_x) < dw) && (13'(in_pos_y) < dh);
    end else begin
      a_pkt_nxt.ok = (13'(in_pos_x) < 13'(sw)) && (13'(in_pos_y) < 13'(sh));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_pkt_r.vld <= 1'b0;
    end else if (adv) begin
      a_pkt_r.vld <= a_pkt_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_pkt_r.cmd  <= a_pkt_nxt.cmd;
      a_pkt_r.ok   <= a_pkt_nxt.ok;
      a_pkt_r.px   <= a_pkt_nxt.px;
      a_pkt_r.py   <= a_pkt_nxt.py;
      a_pkt_r.rgba <= a_pkt_nxt.rgba;
      a_px_r       <= PW'(in_pos_x) * PW'(sw);
      a_py_r       <= PW'(in_pos_y) * PW'(sh);
    end
  end

  // divider stages: source position = (d * s << FB) / ddim
  logic [QW-1:0] sx, sy;

  bis_div u_div_x (
    .clk  (clk),
    .en   (adv),
    .prod (a_px_r),
    .den  (dw),
    .quo  (sx)
  );

  bis_div u_div_y (
    .clk  (clk),
    .en   (adv),
    .prod (a_py_r),
    .den  (dh),
    .quo  (sy)
  );

  // transaction shadow beside the divider
  bis_pkg::pkt_t dv_pkt_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_shadow
    bis_pkg::pkt_t prev;
    if (k == 0) begin : g_first
      assign prev = a_pkt_r;
    end else begin : g_next
      assign prev = dv_pkt_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_pkt_r[k].vld <= 1'b0;
      end else if (adv) begin
        dv_pkt_r[k].vld <= prev.vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_pkt_r[k].cmd  <= prev.cmd;
        dv_pkt_r[k].ok   <= prev.ok;
        dv_pkt_r[k].px   <= prev.px;
        dv_pkt_r[k].py   <= prev.py;
        dv_pkt_r[k].rgba <= prev.rgba;
      end
    end
  end

  // stage c: neighbour coordinates and weights
  bis_pkg::pkt_t c_pkt_r;
  logic [CW-1:0] c_xl_r, c_xu_r;
  logic [RW-1:0] c_yl_r, c_yu_r;
  logic [3:0][WW-1:0] c_wgt_r;

  logic [CW-1:0] xl_nxt, xu_nxt;
  logic [RW-1:0] yl_nxt, yu_nxt;
  logic [FB:0]   fx, fy, gx, gy;
  logic [SDW-1:0] xl_raw, yl_raw, xl_c, yl_c;

  always_comb begin
    xl_raw = SDW'(sx >> FB);
    yl_raw = SDW'(sy >> FB);
    xl_c   = (xl_raw > sw - SDW'(1)) ? sw - SDW'(1) : xl_raw;
    yl_c   = (yl_raw > sh - SDW'(1)) ? sh - SDW'(1) : yl_raw;
    xl_nxt = xl_c[CW-1:0];
    yl_nxt = yl_c[RW-1:0];
    xu_nxt = ((xl_c + SDW'(1)) < sw) ? CW'(xl_c + SDW'(1)) : CW'(sw - SDW'(1));
    yu_nxt = ((yl_c + SDW'(1)) < sh) ? RW'(yl_c + SDW'(1)) : RW'(sh - SDW'(1));
    fx     = {1'b0, sx[FB-1:0]};
    fy     = {1'b0, sy[FB-1:0]};
    gx     = (FB+1)'(1 << FB) - fx;
    gy     = (FB+1)'(1 << FB) - fy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_pkt_r.vld <= 1'b0;
    end else if (adv) begin
      c_pkt_r.vld <= dv_pkt_r[QW-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_pkt_r.cmd  <= dv_pkt_r[QW-1].cmd;
      c_pkt_r.ok   <= dv_pkt_r[QW-1].ok;
      c_pkt_r.px   <= dv_pkt_r[QW-1].px;
      c_pkt_r.py   <= dv_pkt_r[QW-1].py;
      c_pkt_r.rgba <= dv_pkt_r[QW-1].rgba;
      c_xl_r       <= xl_nxt;
      c_xu_r       <= xu_nxt;
      c_yl_r       <= yl_nxt;
      c_yu_r       <= yu_nxt;
      c_wgt_r[0]   <= WW'(gy) * WW'(gx);
      c_wgt_r[1]   <= WW'(gy) * WW'(fx);
      c_wgt_r[2]   <= WW'(fy) * WW'(gx);
      c_wgt_r[3]   <= WW'(fy) * WW'(fx);
    end
  end

  // banked store: bank index is {row parity, column parity}
  logic                 ld_we;
  logic [1:0]           ld_bank;
  logic [AW-1:0]        ld_addr;
  logic [3:0][31:0]     bank_rd;

  assign ld_we   = adv && c_pkt_r.vld && c_pkt_r.ok && (c_pkt_r.cmd == bis_pkg::CMD_LOAD);
  assign ld_bank = {c_pkt_r.py[0], c_pkt_r.px[0]};
  assign ld_addr = {c_pkt_r.py[RW-1:1], c_pkt_r.px[CW-1:1]};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [CW-1:0] xs;
    logic [RW-1:0] ys;
    logic [AW-1:0] raddr;

    // each bank serves whichever neighbour has its parity
    assign xs    = (c_xl_r[0] == b[0]) ? c_xl_r : c_xu_r;
    assign ys    = (c_yl_r[0] == b[1]) ? c_yl_r : c_yu_r;
    assign raddr = {ys[RW-1:1], xs[CW-1:1]};

    bis_ram #(
      .WIDTH (bis_pkg::PIX_W),
      .DEPTH (bis_pkg::BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (ld_we && (ld_bank == 2'(b))),
      .waddr (ld_addr),
      .wdata (c_pkt_r.rgba),
      .re    (adv),
      .raddr (raddr),
      .rdata (bank_rd[b])
    );
  end

  // stage d: read data arrives, steer it to the four taps
  bis_pkg::pkt_t d_pkt_r;
  logic d_xl0_r, d_xu0_r, d_yl0_r, d_yu0_r;
  logic [3:0][WW-1:0] d_wgt_r;
  logic [3:0][31:0]   taps;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_pkt_r.vld <= 1'b0;
    end else if (adv) begin
      d_pkt_r.vld <= c_pkt_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_pkt_r.cmd  <= c_pkt_r.cmd;
      d_pkt_r.ok   <= c_pkt_r.ok;
      d_pkt_r.px   <= c_pkt_r.px;
      d_pkt_r.py   <= c_pkt_r.py;
      d_pkt_r.rgba <= c_pkt_r.rgba;
      d_xl0_r      <= c_xl_r[0];
      d_xu0_r      <= c_xu_r[0];
      d_yl0_r      <= c_yl_r[0];
      d_yu0_r      <= c_yu_r[0];
      d_wgt_r      <= c_wgt_r;
    end
  end

  assign taps[0] = bank_rd[{d_yl0_r, d_xl0_r}];
  assign taps[1] = bank_rd[{d_yl0_r, d_xu0_r}];
  assign taps[2] = bank_rd[{d_yu0_r, d_xl0_r}];
  assign taps[3] = bank_rd[{d_yu0_r, d_xu0_r}];

  // stage e: products inside the interpolator
  bis_pkg::pkt_t e_pkt_r;
  logic [31:0]   e_rgba;

  bis_interp u_interp (
    .clk  (clk),
    .en   (adv),
    .pix  (taps),
    .wgt  (d_wgt_r),
    .rgba (e_rgba)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_pkt_r.vld <= 1'b0;
    end else if (adv) begin
      e_pkt_r.vld <= d_pkt_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_pkt_r.cmd  <= d_pkt_r.cmd;
      e_pkt_r.ok   <= d_pkt_r.ok;
      e_pkt_r.px   <= d_pkt_r.px;
      e_pkt_r.py   <= d_pkt_r.py;
      e_pkt_r.rgba <= d_pkt_r.rgba;
    end
  end

  // output register
  logic [11:0] out_x_r, out_y_r;
  logic [31:0] out_rgba_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= e_pkt_r.vld && e_pkt_r.ok && (e_pkt_r.cmd == bis_pkg::CMD_COMPUTE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r    <= e_pkt_r.px;
      out_y_r    <= e_pkt_r.py;
      out_rgba_r <= e_rgba;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_red   = out_rgba_r[7:0];
  assign out_green = out_rgba_r[15:8];
  assign out_blue  = out_rgba_r[23:16];
  assign out_alpha = out_rgba_r[31:24];

endmodule
